// File: hw/rtl/lgctp_pkg.sv
// shared types, constants and helpers for the lidar gap cluster target picker
package lgctp_pkg;

	// point buffer depth default and result queue size
	localparam int BUFFER_DEPTH_DEF = 512;
	localparam int OUT_FIFO_DEPTH   = 8;
	localparam int OUT_FIFO_AW      = $clog2(OUT_FIFO_DEPTH);
	localparam int OUT_FIFO_CW      = OUT_FIFO_AW + 1;

	// configuration port geometry
	localparam int CFG_DATA_W = 33;
	localparam int CFG_IDX_W  = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAP_THRESHOLD_SQ = 2'd0,
		CFG_OFFSET_X         = 2'd1,
		CFG_OFFSET_Y         = 2'd2,
		CFG_SCOUT_COUNT      = 2'd3
	} cfg_reg_t;

	// register reset values
	localparam logic [32:0] GAP_THRESHOLD_SQ_RST = 33'd65536;
	localparam logic [3:0]  SCOUT_COUNT_RST      = 4'd3;

	// one queued result
	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic [3:0]         robot_number;
		logic               final_of_burst;
	} result_t;

	// signed 16 bit add, saturated to 16 bits
	function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [16:0] s;
		s = {a[15], a} + {b[15], b};
		if (s[16] != s[15]) begin
			sat_add16 = s[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			sat_add16 = s[15:0];
		end
	endfunction

	// round robin step of the robot counter
	function automatic logic [3:0] robot_step(input logic [3:0] t, input logic [3:0] sc);
		logic [4:0] n;
		n = {1'b0, t} + 5'd1;
		robot_step = (n >= {1'b0, sc}) ? 4'd0 : n[3:0];
	endfunction

endpackage

// File: hw/rtl/lidar_gap_cluster_target_picker_core.sv
// lidar gap cluster target picker: point buffer, run tracking and result queue
//
// Usage: scan points enter on the in_valid/in_ready channel, one transaction per
// point (point_x, point_y in signed Q8.8 metres, point_finite, scan_end). A point
// that closes a run of close neighbours yields a target on the out_valid/out_ready
// channel; one point can yield up to two targets, the last one flagged by
// final_of_burst. Registers are written through cfg_we/cfg_index/cfg_data by the user
// only while idle; the block does not enforce this. A target is queued once its point
// has passed stage 1 and stage 2. Throughput: one point per cycle while in_ready is
// high. Each point costs one write and at most one read of the point buffer, a single
// synchronous memory with a registered read. The squared distance multiply, the run
// decision with buffer access and the offset add each take one pipeline stage.
// A small result queue decouples the output: while the receiver stalls, points are
// still taken until the queue has no room left for the worst case of the points in
// flight, then in_ready drops. A point giving two targets drains as two transactions.
// Reset clears registers to their defaults, empties the queue and the pipeline and
// starts a fresh scan; buffer contents are not cleared and need no clearing pass.
module lidar_gap_cluster_target_picker_core #(
	parameter int BUFFER_DEPTH = lgctp_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [lgctp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lgctp_pkg::CFG_DATA_W-1:0]     cfg_data,
	// point input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [15:0]                   point_x,
	input  logic signed [15:0]                   point_y,
	input  logic                                 point_finite,
	input  logic                                 scan_end,
	// target output channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [15:0]                   target_x,
	output logic signed [15:0]                   target_y,
	output logic [3:0]                           robot_number,
	output logic                                 final_of_burst
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam logic [AW:0]   DEPTH_W   = (AW+1)'(BUFFER_DEPTH);
	localparam logic [AW-1:0] RUN_MAX   = AW'(BUFFER_DEPTH - 1);
	localparam logic [AW-1:0] IDX_LAST  = AW'(BUFFER_DEPTH - 1);

	// configuration registers
	logic [32:0]        gap_thr_q;
	logic signed [15:0] off_x_q;
	logic signed [15:0] off_y_q;
	logic [3:0]         scout_q;

	// pending point state
	logic signed [15:0] pend_x_q;
	logic signed [15:0] pend_y_q;
	logic               pend_fin_q;
	logic               have_pend_q;

	// run state
	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] run_cnt_q;
	logic [3:0]    tc_q;

	// stage 1
	logic               v_s1;
	logic signed [15:0] x_s1;
	logic signed [15:0] y_s1;
	logic               fin_s1;
	logic               last_s1;
	logic               hp_s1;
	logic               pfin_s1;
	logic [32:0]        sqx_s1;
	logic [32:0]        sqy_s1;

	// stage 2
	logic               v_s2;
	logic               e1_s2;
	logic               e2_s2;
	logic               bmem_s2;
	logic [3:0]         num_a_s2;
	logic [3:0]         num_b_s2;
	logic signed [15:0] x_s2;
	logic signed [15:0] y_s2;
	logic [31:0]        mem_rdata_s2;

	// point buffer
	logic [31:0] point_mem [BUFFER_DEPTH];

	// result queue
	lgctp_pkg::result_t               fifo_q [lgctp_pkg::OUT_FIFO_DEPTH];
	logic [lgctp_pkg::OUT_FIFO_AW-1:0] rd_ptr_q;
	logic [lgctp_pkg::OUT_FIFO_AW-1:0] wr_ptr_q;
	logic [lgctp_pkg::OUT_FIFO_CW-1:0] cnt_q;

	logic in_acc;
	logic pop;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_thr_q <= lgctp_pkg::GAP_THRESHOLD_SQ_RST;
			off_x_q   <= '0;
			off_y_q   <= '0;
			scout_q   <= lgctp_pkg::SCOUT_COUNT_RST;
		end else if (cfg_we) begin
			case (lgctp_pkg::cfg_reg_t'(cfg_index))
				lgctp_pkg::CFG_GAP_THRESHOLD_SQ: gap_thr_q <= cfg_data[32:0];
				lgctp_pkg::CFG_OFFSET_X:         off_x_q   <= cfg_data[15:0];
				lgctp_pkg::CFG_OFFSET_Y:         off_y_q   <= cfg_data[15:0];
				lgctp_pkg::CFG_SCOUT_COUNT:      scout_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// accept stage: neighbour differences squared
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic signed [33:0] sqx_full;
	logic signed [33:0] sqy_full;

	assign in_acc = in_valid & in_ready;

	always_comb begin
		dx       = {point_x[15], point_x} - {pend_x_q[15], pend_x_q};
		dy       = {point_y[15], point_y} - {pend_y_q[15], pend_y_q};
		sqx_full = 34'(dx) * 34'(dx);
		sqy_full = 34'(dy) * 34'(dy);
	end

	// pending point and stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_x_q    <= '0;
			pend_y_q    <= '0;
			pend_fin_q  <= 1'b0;
			have_pend_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			if (in_acc) begin
				if (scan_end) begin
					pend_x_q    <= '0;
					pend_y_q    <= '0;
					pend_fin_q  <= 1'b0;
					have_pend_q <= 1'b0;
				end else begin
					pend_x_q    <= point_x;
					pend_y_q    <= point_y;
					pend_fin_q  <= point_finite;
					have_pend_q <= 1'b1;
				end
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1    <= point_x;
			y_s1    <= point_y;
			fin_s1  <= point_finite;
			last_s1 <= scan_end;
			hp_s1   <= have_pend_q;
			pfin_s1 <= pend_fin_q;
			sqx_s1  <= sqx_full[32:0];
			sqy_s1  <= sqy_full[32:0];
		end
	end

	// stage 1: run decision, pick addresses, robot numbers
	logic [33:0]   d2;
	logic          close_s1;
	logic          e1;
	logic          e2;
	logic [AW-1:0] rc_a;
	logic [AW-1:0] rc_b;
	logic [AW-1:0] rc_next;
	logic [AW:0]   back1;
	logic [AW:0]   back2;
	logic [AW-1:0] pick1;
	logic [AW-1:0] pick2;
	logic          b_mem;
	logic          mem_re;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] idx_next;
	logic [3:0]    sc;
	logic [3:0]    tc0;
	logic [3:0]    tc1;
	logic [3:0]    tc_mid;
	logic [3:0]    tc_next;

	always_comb begin
		d2       = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		close_s1 = pfin_s1 & fin_s1 & (d2 < {1'b0, gap_thr_q});
		e1       = hp_s1 & pfin_s1 & ~close_s1;
		rc_a     = (hp_s1 && close_s1 && run_cnt_q < RUN_MAX) ? run_cnt_q + 1'b1 : run_cnt_q;
		rc_b     = e1 ? '0 : rc_a;
		rc_next  = last_s1 ? '0 : rc_b;
		e2       = last_s1 & fin_s1;
		// first pick sits behind the previous point, second behind the new one
		back1    = {1'b0, wr_idx_q} + DEPTH_W - ({1'b0, run_cnt_q >> 1} + 1'b1);
		back2    = {1'b0, wr_idx_q} + DEPTH_W - {1'b0, rc_b >> 1};
		pick1    = (back1 >= DEPTH_W) ? AW'(back1 - DEPTH_W) : back1[AW-1:0];
		pick2    = (back2 >= DEPTH_W) ? AW'(back2 - DEPTH_W) : back2[AW-1:0];
		// the second target reads the buffer only if the first did not
		b_mem    = ~e1 & ((rc_b >> 1) != '0);
		mem_re   = v_s1 & (e1 | (e2 & b_mem));
		rd_addr  = e1 ? pick1 : pick2;
		idx_next = (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
		// robot numbers dealt in turn
		sc       = (scout_q == 4'd0) ? 4'd1 : scout_q;
		tc0      = (tc_q >= sc) ? 4'd0 : tc_q;
		tc1      = lgctp_pkg::robot_step(tc0, sc);
		tc_mid   = e1 ? tc1 : tc0;
		if (e2) begin
			tc_next = lgctp_pkg::robot_step(tc_mid, sc);
		end else if (e1) begin
			tc_next = tc1;
		end else begin
			tc_next = tc_q;
		end
	end

	// run state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			run_cnt_q <= '0;
			tc_q      <= '0;
			v_s2      <= 1'b0;
			e1_s2     <= 1'b0;
			e2_s2     <= 1'b0;
		end else begin
			v_s2  <= v_s1;
			e1_s2 <= v_s1 & e1;
			e2_s2 <= v_s1 & e2;
			if (v_s1) begin
				wr_idx_q  <= idx_next;
				run_cnt_q <= rc_next;
				tc_q      <= tc_next;
			end
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (v_s1) begin
			bmem_s2  <= b_mem;
			num_a_s2 <= tc0 + 4'd1;
			num_b_s2 <= tc_mid + 4'd1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
		end
	end

	// point buffer: one write and one read port
	always_ff @(posedge clk) begin
		if (v_s1) begin
			point_mem[wr_idx_q] <= {x_s1, y_s1};
		end
		if (mem_re) begin
			mem_rdata_s2 <= point_mem[rd_addr];
		end
	end

	// stage 2: offset add and saturation
	logic signed [15:0]  mx;
	logic signed [15:0]  my;
	logic signed [15:0]  bx;
	logic signed [15:0]  by;
	lgctp_pkg::result_t  res_a;
	lgctp_pkg::result_t  res_b;
	logic [lgctp_pkg::OUT_FIFO_AW-1:0] wr_ptr_b;
	logic [lgctp_pkg::OUT_FIFO_CW-1:0] push_n;

	always_comb begin
		mx                   = mem_rdata_s2[31:16];
		my                   = mem_rdata_s2[15:0];
		bx                   = bmem_s2 ? mx : x_s2;
		by                   = bmem_s2 ? my : y_s2;
		res_a.target_x       = lgctp_pkg::sat_add16(mx, off_x_q);
		res_a.target_y       = lgctp_pkg::sat_add16(my, off_y_q);
		res_a.robot_number   = num_a_s2;
		res_a.final_of_burst = ~e2_s2;
		res_b.target_x       = lgctp_pkg::sat_add16(bx, off_x_q);
		res_b.target_y       = lgctp_pkg::sat_add16(by, off_y_q);
		res_b.robot_number   = num_b_s2;
		res_b.final_of_burst = 1'b1;
		wr_ptr_b             = wr_ptr_q + {{(lgctp_pkg::OUT_FIFO_AW-1){1'b0}}, e1_s2};
		push_n               = {{(lgctp_pkg::OUT_FIFO_CW-1){1'b0}}, e1_s2}
				+ {{(lgctp_pkg::OUT_FIFO_CW-1){1'b0}}, e2_s2};
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (e1_s2) begin
			fifo_q[wr_ptr_q] <= res_a;
		end
		if (e2_s2) begin
			fifo_q[wr_ptr_b] <= res_b;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[lgctp_pkg::OUT_FIFO_AW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + push_n - {{(lgctp_pkg::OUT_FIFO_CW-1){1'b0}}, pop};
		end
	end

	// input flow control: room for two results per point in flight
	logic [lgctp_pkg::OUT_FIFO_CW:0] room_need;

	always_comb begin
		room_need = {1'b0, cnt_q} + {{(lgctp_pkg::OUT_FIFO_CW-1){1'b0}}, v_s1, 1'b0}
				+ {{(lgctp_pkg::OUT_FIFO_CW-1){1'b0}}, v_s2, 1'b0}
				+ (lgctp_pkg::OUT_FIFO_CW+1)'(2);
		in_ready  = room_need <= (lgctp_pkg::OUT_FIFO_CW+1)'(lgctp_pkg::OUT_FIFO_DEPTH);
	end

	// output side
	assign out_valid      = cnt_q != '0;
	assign pop            = out_valid & out_ready;
	assign target_x       = fifo_q[rd_ptr_q].target_x;
	assign target_y       = fifo_q[rd_ptr_q].target_y;
	assign robot_number   = fifo_q[rd_ptr_q].robot_number;
	assign final_of_burst = fifo_q[rd_ptr_q].final_of_burst;

endmodule

// File: hw/rtl/lgctp_checker.sv
// port level checks for the target picker, bound to the top level
module lgctp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] target_x,
	input logic signed [15:0] target_y,
	input logic [3:0]         robot_number,
	input logic               final_of_burst
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target_x) && $stable(target_y)
			&& $stable(robot_number) && $stable(final_of_burst))
	else $error("stalled result changed");

	// second result of a burst is queued together with the first
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_of_burst |=> out_valid)
	else $error("burst broken up");

	// robot numbers start from one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> robot_number != 4'd0)
	else $error("robot number zero");

	// within a burst the robot number advances or wraps to one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_of_burst |=>
			robot_number == $past(robot_number) + 4'd1 || robot_number == 4'd1)
	else $error("robot number out of turn");

endmodule

bind lidar_gap_cluster_target_picker_core lgctp_checker u_lgctp_checker (.*);

// File: verif/tb_top.sv
// testbench for the lidar gap cluster target picker core: directed and random scans
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH         = lgctp_pkg::BUFFER_DEPTH_DEF;
	localparam int IW            = $clog2(DEPTH);
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 200;

	// one scan point as offered on the input channel
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               fin;
		logic               is_last;
	} scan_pt_t;

	// block ports, the inputs known from time zero
	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [lgctp_pkg::CFG_IDX_W-1:0]     cfg_index = lgctp_pkg::CFG_GAP_THRESHOLD_SQ;
	logic [lgctp_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic signed [15:0]                  point_x = '0;
	logic signed [15:0]                  point_y = '0;
	logic                                point_finite = 1'b0;
	logic                                scan_end = 1'b0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [15:0]                  target_x;
	logic signed [15:0]                  target_y;
	logic [3:0]                          robot_number;
	logic                                final_of_burst;

	// points still to offer and targets still to arrive
	scan_pt_t           point_q[$];
	lgctp_pkg::result_t target_q[$];
	int                 points_waiting = 0;
	int                 mismatches = 0;

	// register copies
	logic [32:0]        thr_sq = lgctp_pkg::GAP_THRESHOLD_SQ_RST;
	logic signed [15:0] ofs_x = '0;
	logic signed [15:0] ofs_y = '0;
	logic [3:0]         scouts = lgctp_pkg::SCOUT_COUNT_RST;

	// scan tracking state
	logic signed [15:0] store_x [DEPTH];
	logic signed [15:0] store_y [DEPTH];
	logic signed [15:0] prev_x = '0;
	logic signed [15:0] prev_y = '0;
	logic               prev_fin = 1'b0;
	logic               have_prev = 1'b0;
	logic [IW-1:0]      wr_idx = '0;
	logic [IW-1:0]      run_len = '0;
	logic [3:0]         robot_ctr = '0;

	lidar_gap_cluster_target_picker_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.point_x        (point_x),
		.point_y        (point_y),
		.point_finite   (point_finite),
		.scan_end       (scan_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.target_x       (target_x),
		.target_y       (target_y),
		.robot_number   (robot_number),
		.final_of_burst (final_of_burst)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// limit on the whole run
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// squared distance strictly below the threshold
	function automatic logic near(input logic signed [15:0] ax, input logic signed [15:0] ay,
			input logic signed [15:0] bx, input logic signed [15:0] by);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return (dx * dx + dy * dy) < longint'({31'b0, thr_sq});
	endfunction

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// target from the middle of the run ending at store entry at, robot dealt in turn
	function automatic lgctp_pkg::result_t pick_target(input logic [IW-1:0] at);
		lgctp_pkg::result_t r;
		logic [3:0]         sc;
		logic [IW-1:0]      pick;
		sc = (scouts == 4'd0) ? 4'd1 : scouts;
		pick = at - (run_len >> 1);
		if (robot_ctr >= sc) robot_ctr = 4'd0;
		r.target_x = clamp16(int'(store_x[pick]) + int'(ofs_x));
		r.target_y = clamp16(int'(store_y[pick]) + int'(ofs_y));
		r.robot_number = robot_ctr + 4'd1;
		r.final_of_burst = 1'b0;
		robot_ctr = (int'(robot_ctr) + 1 >= int'(sc)) ? 4'd0 : robot_ctr + 4'd1;
		run_len = '0;
		return r;
	endfunction

	// targets caused by one accepted point
	task automatic predict_point(input scan_pt_t p);
		lgctp_pkg::result_t r [2];
		int                 n;
		logic [IW-1:0]      idx;
		n = 0;
		idx = wr_idx;
		// previous point judged against this one
		if (have_prev) begin
			if (prev_fin && p.fin && near(prev_x, prev_y, p.x, p.y)) begin
				if (int'(run_len) < DEPTH - 1) run_len = run_len + 1'b1;
			end else if (prev_fin) begin
				r[n] = pick_target(idx - 1'b1);
				n++;
			end
		end
		store_x[idx] = p.x;
		store_y[idx] = p.y;
		wr_idx = idx + 1'b1;
		// last point of a scan has no successor
		if (p.is_last) begin
			if (p.fin) begin
				r[n] = pick_target(idx);
				n++;
			end
			have_prev = 1'b0;
			run_len = '0;
			prev_x = '0;
			prev_y = '0;
			prev_fin = 1'b0;
		end else begin
			prev_x = p.x;
			prev_y = p.y;
			prev_fin = p.fin;
			have_prev = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			r[i].final_of_burst = (i == n - 1);
			target_q.insert(target_q.size(), r[i]);
		end
	endtask

	// sender: bursts of random length with random gaps
	int       burst_left = 1;
	int       gap_left = 0;
	scan_pt_t cur_pt = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_point(cur_pt);
				points_waiting--;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (point_q.size() != 0) begin
					cur_pt = point_q.pop_front();
					point_x <= cur_pt.x;
					point_y <= cur_pt.y;
					point_finite <= cur_pt.fin;
					scan_end <= cur_pt.is_last;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						// now and then a long burst with no gap
						if ($urandom_range(0, 3) == 0) begin
							burst_left = $urandom_range(30, 120);
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 12);
							gap_left = $urandom_range(1, 6);
						end
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall modes that change over time, plus long hold-offs
	int rx_count = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				rx_count++;
				if (rx_count == 40 || rx_count % 150 == 0) hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					rx_mode_left = $urandom_range(16, 96);
				end else begin
					rx_mode_left--;
				end
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// monitor: each target transaction against the oldest expectation
	always @(posedge clk) begin
		lgctp_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (target_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected target: x=%0d y=%0d robot=%0d final=%0d",
						target_x, target_y, robot_number, final_of_burst);
			end else begin
				want = target_q.pop_front();
				if (want.target_x !== target_x || want.target_y !== target_y ||
						want.robot_number !== robot_number ||
						want.final_of_burst !== final_of_burst) begin
					mismatches++;
					if (mismatches <= 10)
						$display("target mismatch: expected x=%0d y=%0d robot=%0d final=%0d,",
							want.target_x, want.target_y, want.robot_number,
							want.final_of_burst,
							" got x=%0d y=%0d robot=%0d final=%0d",
							target_x, target_y, robot_number, final_of_burst);
				end
			end
		end
	end

	task automatic add_pt(input logic [15:0] x, input logic [15:0] y, input logic fin,
			input logic is_last);
		scan_pt_t p;
		p.x = x;
		p.y = y;
		p.fin = fin;
		p.is_last = is_last;
		point_q.insert(point_q.size(), p);
		points_waiting++;
	endtask

	// mostly scans as random walks, some noise points
	task automatic add_scans(input int count);
		int          made;
		int          len;
		int          span;
		int          dx;
		int          dy;
		logic [15:0] px;
		logic [15:0] py;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 9) == 0) begin
				add_pt(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				made++;
			end else begin
				len = $urandom_range(1, 40);
				case ($urandom_range(0, 3))
					0: span = 4;
					1: span = 40;
					2: span = 200;
					default: span = 1200;
				endcase
				px = 16'($urandom);
				py = 16'($urandom);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0) begin
						px = 16'($urandom);
						py = 16'($urandom);
					end else begin
						dx = int'($urandom_range(0, 2 * span)) - span;
						dy = int'($urandom_range(0, 2 * span)) - span;
						px = px + dx[15:0];
						py = py + dy[15:0];
					end
					add_pt(px, py, $urandom_range(0, 9) != 0, i == len - 1);
				end
				made += len;
			end
		end
	endtask

	// one unbroken run of finite points ending the scan
	task automatic add_long_run(input int len);
		logic [15:0] px;
		logic [15:0] py;
		int          dx;
		px = 16'($urandom);
		py = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			dx = $urandom_range(0, 8);
			px = px + dx[15:0] - 16'd4;
			py = py + 16'd1;
			add_pt(px, py, 1'b1, i == len - 1);
		end
	endtask

	task automatic write_reg(input lgctp_pkg::cfg_reg_t r,
			input logic [lgctp_pkg::CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			lgctp_pkg::CFG_GAP_THRESHOLD_SQ: thr_sq = v[32:0];
			lgctp_pkg::CFG_OFFSET_X:         ofs_x = v[15:0];
			lgctp_pkg::CFG_OFFSET_Y:         ofs_y = v[15:0];
			lgctp_pkg::CFG_SCOUT_COUNT:      scouts = v[3:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [32:0] thr, input logic [15:0] ox,
			input logic [15:0] oy, input logic [3:0] sc);
		write_reg(lgctp_pkg::CFG_GAP_THRESHOLD_SQ, thr);
		write_reg(lgctp_pkg::CFG_OFFSET_X, {17'b0, ox});
		write_reg(lgctp_pkg::CFG_OFFSET_Y, {17'b0, oy});
		write_reg(lgctp_pkg::CFG_SCOUT_COUNT, {29'b0, sc});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every point taken and every target seen, then let the pipeline empty
	task automatic wait_idle();
		int waited;
		waited = 0;
		while ((points_waiting != 0 || target_q.size() != 0) && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (waited >= DRAIN_LIMIT) begin
			mismatches++;
			$display("drain stuck: %0d points and %0d targets outstanding",
				points_waiting, target_q.size());
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// stimulus sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed scans at reset settings
		add_pt(16'h7fff, 16'h8000, 1'b1, 1'b1);  // lone finite scan
		add_pt(16'h8000, 16'h7fff, 1'b0, 1'b1);  // lone infinite scan
		add_pt(16'd0, 16'd0, 1'b1, 1'b0);
		add_pt(16'd16, 16'd0, 1'b1, 1'b0);
		add_pt(16'd32, 16'd16, 1'b1, 1'b0);
		add_pt(16'h4000, 16'd0, 1'b1, 1'b0);     // gap closes a run of three
		add_pt(16'd0, 16'd0, 1'b0, 1'b0);        // infinite successor closes the run
		add_pt(16'd0, 16'd0, 1'b0, 1'b0);        // infinite after infinite
		add_pt(16'd100, 16'd100, 1'b1, 1'b0);
		add_pt(16'd355, 16'd100, 1'b1, 1'b0);    // just inside the threshold
		add_pt(16'd611, 16'd100, 1'b1, 1'b0);    // exactly on the threshold
		add_pt(16'h8000, 16'h8000, 1'b1, 1'b0);
		add_pt(16'h7fff, 16'h7fff, 1'b1, 1'b1);  // gap and scan end together
		add_pt(16'd5, 16'd5, 1'b1, 1'b0);
		add_pt(16'd6, 16'd6, 1'b1, 1'b1);        // close run closed by scan end
		add_pt(16'd0, 16'd0, 1'b0, 1'b1);
		add_pt(16'd10, 16'd10, 1'b1, 1'b0);
		add_pt(16'd10, 16'd10, 1'b0, 1'b1);      // infinite end after finite
		add_pt(16'd0, 16'd0, 1'b1, 1'b0);
		add_pt(16'd181, 16'd181, 1'b1, 1'b0);    // diagonal inside the threshold
		add_pt(16'hffff, 16'hffff, 1'b1, 1'b1);
		wait_idle();

		// nothing close, offsets saturating, many robots
		set_config(33'd0, 16'h7fff, 16'h8000, 4'd15);
		add_scans(130);
		wait_idle();

		// everything close, long run saturates, fewer robots than the counter
		set_config(33'h1_ffff_ffff, 16'h8000, 16'h7fff, 4'd2);
		add_long_run(520);
		add_scans(130);
		wait_idle();

		// no robots counts as one
		set_config(33'h10_0000, 16'($urandom), 16'($urandom), 4'd0);
		add_scans(130);
		wait_idle();

		// only identical neighbours are close
		set_config(33'd1, 16'd0, 16'd0, 4'd1);
		add_scans(130);
		wait_idle();

		set_config(33'd300000, 16'd256, 16'hff00, 4'd7);
		add_scans(80);
		wait_idle();

		if (target_q.size() != 0) begin
			mismatches++;
			$display("%0d targets never arrived", target_q.size());
		end
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
